@@ design/chol_pkg.sv @@
// Shared types, constants and the controller state encoding for the Cholesky solver.
`timescale 1ns / 1ps
package chol_pkg;
  localparam int unsigned DimDefault = 8;
  localparam int unsigned MaxDim     = 16;

  typedef struct packed {
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic               is_rhs;
    logic signed [31:0] entry_value;
    logic               last_entry;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]         solution_index;
    logic signed [31:0] solution_value;
    logic               pivot_error;
    logic               last_result;
  } out_beat_t;

  // Datapath operations chosen by the controller.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,   // acc <= operand * 2^16
    OP_MAC,    // acc <= clamp(acc - a * b)
    OP_SQRT,   // iterative square root of acc
    OP_DIV,    // iterative division acc / pivot
    OP_CLEAR   // zero solution vector
  } dp_op_e;

  // Which stores feed the operands.
  typedef enum logic [2:0] {
    SRC_A,      // matrix A[i][j]
    SRC_B,      // rhs b[i]
    SRC_Y,      // work vector y[i]
    SRC_LL,     // L[i][k] * L[j][k]
    SRC_LY,     // L[i][j] * y[j]
    SRC_LX      // L[j][i] * x[j]
  } dp_src_e;

  typedef enum logic [1:0] {
    DST_L,
    DST_Y,
    DST_X
  } dp_dst_e;

  typedef struct packed {
    dp_op_e     op;
    dp_src_e    src;
    dp_dst_e    dst;
    logic [3:0] i;
    logic [3:0] j;
    logic [3:0] k;
    logic       start;   // pulse: begin a multi-cycle op
  } dp_cmd_t;

  typedef struct packed {
    logic busy;      // sqrt or divide starting, in progress or writing back
    logic neg_pivot; // acc <= 0 at a sqrt
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FAC_LOAD,
    ST_FAC_MAC,
    ST_FAC_FIN,
    ST_FAC_WAIT,
    ST_FW_LOAD,
    ST_FW_MAC,
    ST_FW_WAIT,
    ST_BW_LOAD,
    ST_BW_MAC,
    ST_BW_WAIT,
    ST_OUT
  } ctrl_state_e;

  localparam logic signed [63:0] AccMax = 64'sh3FFF_FFFF_FFFF_FFFF;
endpackage

@@ design/chol_datapath.sv @@
// Datapath: stores, multiply-accumulate, iterative square root and divider.
`timescale 1ns / 1ps
module chol_datapath import chol_pkg::*; #(
  parameter int unsigned DIM = DimDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_en_i,
  input  in_beat_t  wr_beat_i,
  input  dp_cmd_t   cmd_i,
  input  logic [3:0] rd_idx_i,
  output logic signed [31:0] rd_val_o,
  output dp_stat_t  stat_o
);
  localparam int unsigned Depth = DIM * DIM;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned IW = (DIM > 1) ? $clog2(DIM) : 1;

  logic signed [31:0] a_mem [Depth];
  logic signed [31:0] l_mem [Depth];
  logic signed [31:0] b_reg [DIM];
  logic signed [31:0] y_reg [DIM];
  logic signed [31:0] x_reg [DIM];

  function automatic logic [AW-1:0] addr(input logic [3:0] r, input logic [3:0] c);
    logic [15:0] t;
    t = 16'(r) * 16'(DIM) + 16'(c);
    return t[AW-1:0];
  endfunction

  // Matrix A write port (load phase only).
  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_beat_i.is_rhs && 32'(wr_beat_i.row_index) < DIM &&
        32'(wr_beat_i.col_index) < DIM) begin
      a_mem[addr(wr_beat_i.row_index, wr_beat_i.col_index)] <= wr_beat_i.entry_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_beat_i.is_rhs && 32'(wr_beat_i.row_index) < DIM) begin
      b_reg[wr_beat_i.row_index[IW-1:0]] <= wr_beat_i.entry_value;
    end
  end

  // Registered reads of L at two addresses, of A and of one vector store.
  logic signed [31:0] a_rd_q, l0_rd_q, l1_rd_q, v_rd_q;
  logic [AW-1:0] l0_addr, l1_addr;
  always_comb begin
    l0_addr = addr(cmd_i.i, cmd_i.k);
    l1_addr = addr(cmd_i.j, cmd_i.k);
    unique case (cmd_i.src)
      SRC_LY:  begin l0_addr = addr(cmd_i.i, cmd_i.j); l1_addr = l0_addr; end
      SRC_LX:  begin l0_addr = addr(cmd_i.j, cmd_i.i); l1_addr = l0_addr; end
      default: ;
    endcase
    // a divide start fetches its pivot through the first port
    if (cmd_i.op == OP_DIV) begin
      l0_addr = (cmd_i.dst == DST_L) ? addr(cmd_i.j, cmd_i.j) : addr(cmd_i.i, cmd_i.i);
    end
  end

  dp_cmd_t cmd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
    end else begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_rd_q  <= a_mem[addr(cmd_i.i, cmd_i.j)];
    l0_rd_q <= l_mem[l0_addr];
    l1_rd_q <= l_mem[l1_addr];
    unique case (cmd_i.src)
      SRC_B:   v_rd_q <= b_reg[cmd_i.i[IW-1:0]];
      SRC_Y:   v_rd_q <= y_reg[cmd_i.i[IW-1:0]];
      SRC_LY:  v_rd_q <= y_reg[cmd_i.j[IW-1:0]];
      SRC_LX:  v_rd_q <= x_reg[cmd_i.j[IW-1:0]];
      default: v_rd_q <= '0;
    endcase
  end

  // Stage 2: product register.
  logic signed [63:0] prod_q;
  dp_cmd_t cmd2_q;
  logic signed [31:0] opnd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd2_q <= '0;
    end else begin
      cmd2_q <= cmd_q;
    end
  end
  always_ff @(posedge clk_i) begin
    opnd_q <= (cmd_q.src == SRC_A) ? a_rd_q : v_rd_q;
    if (cmd_q.src == SRC_LL) prod_q <= l0_rd_q * l1_rd_q;
    else                     prod_q <= l0_rd_q * v_rd_q;
  end

  // Accumulator.
  logic signed [63:0] acc_q, acc_d;
  logic signed [64:0] diff;
  always_comb begin
    diff  = 65'(acc_q) - 65'(prod_q);
    acc_d = acc_q;
    if (cmd2_q.op == OP_LOAD) begin
      acc_d = 64'(opnd_q) <<< 16;
    end else if (cmd2_q.op == OP_MAC) begin
      if (diff > 65'(AccMax))       acc_d = AccMax;
      else if (diff < -65'(AccMax)) acc_d = -AccMax;
      else                          acc_d = diff[63:0];
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Shared iterative unit: square root (two bits a step) or restoring divide.
  logic        run_q, is_sqrt_q, neg_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q, res_q, bit_q;
  logic [63:0] num_q;
  logic [31:0] den_q;
  logic        sign_q;
  logic [64:0] drem_q;
  dp_dst_e     dst_q;
  logic [3:0]  wi_q, wj_q;
  logic signed [31:0] piv2_q;

  always_ff @(posedge clk_i) begin
    piv2_q <= l0_rd_q;
  end

  logic        wr_l, wr_v;
  logic signed [31:0] wr_val;
  logic [64:0] dtrial;
  logic [63:0] qv;
  logic [63:0] qmag;

  always_comb begin
    dtrial = {drem_q[63:0], num_q[63]} - {33'd0, den_q};
    qmag   = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      is_sqrt_q <= 1'b0;
      neg_q     <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (cmd2_q.start) begin
        dst_q <= cmd2_q.dst;
        wi_q  <= cmd2_q.i;
        wj_q  <= cmd2_q.j;
        if (cmd2_q.op == OP_SQRT) begin
          is_sqrt_q <= 1'b1;
          neg_q     <= (acc_q <= 0);
          run_q     <= 1'b1;
          rem_q     <= acc_q;
          res_q     <= '0;
          bit_q     <= 64'd1 << 62;
          cnt_q     <= 6'd31;
        end else begin
          is_sqrt_q <= 1'b0;
          neg_q     <= (piv2_q <= 0);
          run_q     <= 1'b1;
          sign_q    <= acc_q[63];
          num_q     <= acc_q[63] ? 64'(-acc_q) : acc_q;
          den_q     <= piv2_q;
          drem_q    <= '0;
          res_q     <= '0;
          cnt_q     <= 6'd63;
        end
      end else if (run_q) begin
        if (is_sqrt_q) begin
          if (rem_q >= res_q + bit_q) begin
            rem_q <= rem_q - (res_q + bit_q);
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          if (!dtrial[64]) begin
            drem_q <= dtrial;
            res_q  <= {res_q[62:0], 1'b1};
          end else begin
            drem_q <= {drem_q[63:0], num_q[63]};
            res_q  <= {res_q[62:0], 1'b0};
          end
          num_q <= {num_q[62:0], 1'b0};
        end
        if (cnt_q == 6'd0) run_q <= 1'b0;
        else               cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  // Write-back when the unit finishes; its last step ran with cnt_q == 0.
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= run_q && cnt_q == 6'd0;
  end

  always_comb begin
    wr_val = '0;
    if (!neg_q) begin
      if (is_sqrt_q) begin
        wr_val = (qmag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : qmag[31:0];
      end else begin
        qv = sign_q ? 64'(-qmag) : qmag;
        if (!sign_q && qmag > 64'h7FFF_FFFF)     wr_val = 32'sh7FFF_FFFF;
        else if (sign_q && qmag > 64'h8000_0000) wr_val = 32'sh8000_0000;
        else                                     wr_val = qv[31:0];
      end
    end
    qv   = sign_q ? 64'(-qmag) : qmag;
    wr_l = done_q && dst_q == DST_L;
    wr_v = done_q && dst_q != DST_L;
  end

  always_ff @(posedge clk_i) begin
    if (wr_l) l_mem[addr(wi_q, wj_q)] <= wr_val;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CLEAR) begin
      for (int n = 0; n < DIM; n++) x_reg[n] <= '0;
    end else if (wr_v && dst_q == DST_X) begin
      x_reg[wi_q[IW-1:0]] <= wr_val;
    end
    if (wr_v && dst_q == DST_Y) y_reg[wi_q[IW-1:0]] <= wr_val;
  end

  assign rd_val_o = x_reg[rd_idx_i[IW-1:0]];

  assign stat_o.busy      = run_q || done_q || cmd_q.start || cmd2_q.start;
  assign stat_o.neg_pivot = neg_q && is_sqrt_q && done_q;
endmodule

@@ design/chol_ctrl.sv @@
// Controller: sequences factorization, substitutions and result beats.
`timescale 1ns / 1ps
module chol_ctrl import chol_pkg::*; #(
  parameter int unsigned DIM = DimDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_stall_o,
  output dp_cmd_t   cmd_o,
  input  dp_stat_t  stat_i,
  output logic [3:0] rd_idx_o,
  input  logic signed [31:0] rd_val_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);
  localparam logic [3:0] Last = 4'(DIM - 1);

  ctrl_state_e state_q, state_d;
  logic [3:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic       err_q, err_d;
  logic       ov_q, ov_d;
  out_beat_t  ob_q, ob_d;
  logic [2:0] drain_q, drain_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q <= '0; j_q <= '0; k_q <= '0;
      err_q <= 1'b0; ov_q <= 1'b0; drain_q <= '0;
    end else begin
      state_q <= state_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d;
      err_q <= err_d; ov_q <= ov_d; drain_q <= drain_d;
    end
  end
  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
  end

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; k_d = k_q;
    err_d = err_q | stat_i.neg_pivot;
    ov_d  = ov_q;
    ob_d  = ob_q;
    drain_d = drain_q;
    cmd_o = '0;
    cmd_o.i = i_q; cmd_o.j = j_q; cmd_o.k = k_q;
    in_stall_o = 1'b1;
    rd_idx_o = i_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && in_last_i) begin
          state_d = ST_FAC_LOAD;
          i_d = '0; j_d = '0; k_d = '0; err_d = 1'b0;
        end
      end
      ST_FAC_LOAD: begin
        if (!stat_i.busy) begin
          cmd_o.op = OP_LOAD; cmd_o.src = SRC_A;
          k_d = '0;
          state_d = (j_q == 4'd0) ? ST_FAC_FIN : ST_FAC_MAC;
          drain_d = 3'd2;
        end
      end
      ST_FAC_MAC: begin
        cmd_o.op = OP_MAC; cmd_o.src = SRC_LL;
        if (k_q + 4'd1 == j_q) state_d = ST_FAC_FIN;
        else                   k_d = k_q + 4'd1;
        drain_d = 3'd2;
      end
      ST_FAC_FIN: begin
        // wait for the pipelined sums to land in the accumulator
        if (drain_q != 3'd0) begin
          drain_d = drain_q - 3'd1;
        end else begin
          cmd_o.start = 1'b1; cmd_o.dst = DST_L;
          cmd_o.op = (i_q == j_q) ? OP_SQRT : OP_DIV;
          state_d = ST_FAC_WAIT;
        end
      end
      ST_FAC_WAIT: begin
        cmd_o.op = OP_IDLE;
        if (!stat_i.busy) begin
          if (j_q == i_q) begin
            if (i_q == Last) begin
              i_d = '0; j_d = '0;
              state_d = err_d ? ST_OUT : ST_FW_LOAD;
              if (err_d) begin
                cmd_o.op = OP_CLEAR;
              end
            end else begin
              i_d = i_q + 4'd1; j_d = '0; state_d = ST_FAC_LOAD;
            end
          end else begin
            j_d = j_q + 4'd1; state_d = ST_FAC_LOAD;
          end
        end
      end
      ST_FW_LOAD: begin
        // the row's sum reads the y element that the last divide produces
        if (drain_q != 3'd0) begin
          drain_d = drain_q - 3'd1;
        end else if (!stat_i.busy) begin
          cmd_o.op = OP_LOAD; cmd_o.src = SRC_B;
          j_d = '0; drain_d = 3'd2;
          state_d = (i_q == 4'd0) ? ST_FW_WAIT : ST_FW_MAC;
        end
      end
      ST_FW_MAC: begin
        cmd_o.op = OP_MAC; cmd_o.src = SRC_LY;
        if (j_q + 4'd1 == i_q) state_d = ST_FW_WAIT;
        else                   j_d = j_q + 4'd1;
        drain_d = 3'd2;
      end
      ST_FW_WAIT: begin
        if (drain_q != 3'd0) begin
          drain_d = drain_q - 3'd1;
        end else if (!stat_i.busy) begin
          cmd_o.op = OP_DIV; cmd_o.start = 1'b1; cmd_o.dst = DST_Y;
          state_d = ST_FW_LOAD;
          drain_d = 3'd4;
          if (i_q == Last) state_d = ST_BW_LOAD;
          else             i_d = i_q + 4'd1;
        end
      end
      ST_BW_LOAD: begin
        // drain_q first lets the last y divide get under way
        if (drain_q != 3'd0) begin
          drain_d = drain_q - 3'd1;
        end else if (!stat_i.busy) begin
          cmd_o.op = OP_LOAD; cmd_o.src = SRC_Y;
          j_d = i_q + 4'd1; drain_d = 3'd2;
          state_d = (i_q == Last) ? ST_BW_WAIT : ST_BW_MAC;
        end
      end
      ST_BW_MAC: begin
        cmd_o.op = OP_MAC; cmd_o.src = SRC_LX;
        if (j_q == Last) state_d = ST_BW_WAIT;
        else             j_d = j_q + 4'd1;
        drain_d = 3'd2;
      end
      ST_BW_WAIT: begin
        if (drain_q != 3'd0) begin
          drain_d = drain_q - 3'd1;
        end else begin
          cmd_o.op = OP_DIV; cmd_o.start = 1'b1; cmd_o.dst = DST_X;
          drain_d = 3'd4;
          if (i_q == 4'd0) begin
            state_d = ST_OUT;
          end else begin
            i_d = i_q - 4'd1; state_d = ST_BW_LOAD;
          end
        end
      end
      ST_OUT: begin
        if (drain_q != 3'd0) begin
          drain_d = drain_q - 3'd1;
        end else if (!stat_i.busy && (!ov_q || !out_stall_i)) begin
          ov_d = 1'b1;
          ob_d.solution_index = i_q;
          ob_d.solution_value = rd_val_i;
          ob_d.pivot_error    = err_q;
          ob_d.last_result    = (i_q == Last);
          if (i_q == Last) state_d = ST_IDLE;
          else             i_d = i_q + 4'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_beat_o  = ob_q;
endmodule

@@ design/cholesky_spd_solver_unit.sv @@
// Top level of the Cholesky SPD linear solver.
//
// Input channel: one beat per matrix or rhs entry (Q16.16); entries load one
// per cycle. The beat with last_entry set is stored and starts the solve;
// the input is stalled until the final result beat has been issued.
// Solve time is set by the shared sqrt/divide unit, which runs one square root or
// divide at a time; each element also adds its inner product terms and its load
// and drain. A solve runs DIM square roots and DIM*(DIM-1)/2 + 2*DIM divides.
// Output channel: DIM beats in index order, the final one marked with
// last_result. A non-positive pivot returns all zeros with pivot_error set.
// A held output beat stays in its register while out_stall_i is high; the
// sequencer waits for it before issuing the next beat.
// Reset clears the controller; stores are undefined until written.
`timescale 1ns / 1ps
module cholesky_spd_solver_unit import chol_pkg::*; #(
  parameter int unsigned DIM = DimDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [3:0] rd_idx;
  logic signed [31:0] rd_val;
  logic wr_en;

  assign wr_en = in_valid_i && !in_stall_o;

  chol_ctrl #(.DIM(DIM)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_last_i(in_beat_i.last_entry), .in_stall_o,
    .cmd_o(cmd), .stat_i(stat), .rd_idx_o(rd_idx), .rd_val_i(rd_val),
    .out_valid_o, .out_stall_i, .out_beat_o
  );

  chol_datapath #(.DIM(DIM)) u_dp (
    .clk_i, .rst_ni,
    .wr_en_i(wr_en), .wr_beat_i(in_beat_i),
    .cmd_i(cmd), .rd_idx_i(rd_idx), .rd_val_o(rd_val), .stat_o(stat)
  );
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the Cholesky SPD solver: directed table plus random solves.
`timescale 1ns / 1ps
module testbench;
  import chol_pkg::*;

  localparam int unsigned N = DimDefault;
  localparam longint AccLim = 64'sh3FFF_FFFF_FFFF_FFFF;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  cholesky_spd_solver_unit #(.DIM(N)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_beat_i,
    .out_valid_o, .out_stall_i, .out_beat_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("%0t: timeout", $time);
    $display("testbench: errors");
    $finish;
  end

  // Shadow copy of the block's stores
  logic signed [31:0] a_mat [N*N];
  logic signed [31:0] b_vec [N];
  logic signed [31:0] l_mat [N*N];
  logic signed [31:0] y_vec [N];

  out_beat_t solution_q[$];
  int n_err = 0;
  int n_items = 0;
  int n_solves = 0;
  int n_pivot_fail = 0;
  int n_results = 0;
  int out_hold = 0;
  bit calm = 1'b0;
  bit drained = 1'b0;

  typedef struct {
    in_beat_t           beat;
    bit                 typed;
    logic signed [31:0] tval;
    bit                 terr;
  } drow_t;

  drow_t dtab[$];

  function automatic longint clamp_acc(longint v);
    if (v > AccLim) return AccLim;
    if (v < -AccLim) return -AccLim;
    return v;
  endfunction

  function automatic logic signed [31:0] sat_q(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] quot_q(longint num, logic signed [31:0] den);
    if (den <= 0) return '0;
    return sat_q(num / longint'(den));
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bt;
    res = '0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint prod(logic signed [31:0] a, logic signed [31:0] b);
    return longint'(a) * longint'(b);
  endfunction

  // Stores the beat and works out the solution from the shadow stores.
  task automatic solve_predict(in_beat_t bt, output out_beat_t sol_o[N], output bit fail);
    logic signed [31:0] x [N];
    longint acc;
    fail = 1'b0;
    if (bt.is_rhs) begin
      if (bt.row_index < N) b_vec[bt.row_index] = bt.entry_value;
    end else if (bt.row_index < N && bt.col_index < N) begin
      a_mat[bt.row_index*N + bt.col_index] = bt.entry_value;
    end
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j <= i; j++) begin
        acc = longint'(a_mat[i*N+j]) * 65536;
        for (int k = 0; k < j; k++) acc = clamp_acc(acc - prod(l_mat[i*N+k], l_mat[j*N+k]));
        if (i == j) begin
          if (acc <= 0) begin
            fail = 1'b1;
            l_mat[i*N+i] = '0;
          end else begin
            l_mat[i*N+i] = sat_q(longint'(root_floor(acc)));
          end
        end else begin
          l_mat[i*N+j] = quot_q(acc, l_mat[j*N+j]);
        end
      end
    end
    for (int i = 0; i < N; i++) x[i] = '0;
    if (!fail) begin
      for (int i = 0; i < N; i++) begin
        acc = longint'(b_vec[i]) * 65536;
        for (int j = 0; j < i; j++) acc = clamp_acc(acc - prod(l_mat[i*N+j], y_vec[j]));
        y_vec[i] = quot_q(acc, l_mat[i*N+i]);
      end
      for (int i = N - 1; i >= 0; i--) begin
        acc = longint'(y_vec[i]) * 65536;
        for (int j = i + 1; j < N; j++) acc = clamp_acc(acc - prod(l_mat[j*N+i], x[j]));
        x[i] = quot_q(acc, l_mat[i*N+i]);
      end
    end
    for (int i = 0; i < N; i++) begin
      sol_o[i].solution_index = i[3:0];
      sol_o[i].solution_value = x[i];
      sol_o[i].pivot_error    = fail;
      sol_o[i].last_result    = (i == N - 1);
    end
  endtask

  function automatic in_beat_t mk(int r, int c, bit rhs, logic [31:0] v, bit last);
    in_beat_t b;
    b.row_index   = r[3:0];
    b.col_index   = c[3:0];
    b.is_rhs      = rhs;
    b.entry_value = v;
    b.last_entry  = last;
    return b;
  endfunction

  function automatic drow_t row(in_beat_t b, bit typed = 0, logic [31:0] tv = '0, bit te = 0);
    drow_t d;
    d.beat = b; d.typed = typed; d.tval = tv; d.terr = te;
    return d;
  endfunction

  // Drives one beat, waits for acceptance, then updates the prediction.
  task automatic send(in_beat_t bt, bit typed = 0, logic [31:0] tv = '0, bit te = 0);
    int gap;
    out_beat_t sol[N];
    bit fail;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_beat_i  = bt;
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
    solve_predict(bt, sol, fail);
    if (bt.last_entry) begin
      n_solves++;
      if (fail) n_pivot_fail++;
      for (int i = 0; i < N; i++) begin
        if (typed) begin
          sol[i].solution_value = tv;
          sol[i].pivot_error    = te;
        end
        solution_q.push_back(sol[i]);
      end
    end
    @(negedge clk_i);
  endtask

  // Receiver side: sample at posedge, stall decided at negedge
  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i = (out_hold > 0);
      if (out_hold > 0) out_hold--;
    end
  end

  initial begin
    out_beat_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        n_results++;
        out_hold = calm ? 0 : $urandom_range(0, 8);
        if (solution_q.size() == 0) begin
          $display("%0t: result beat with none expected: %p", $time, out_beat_o);
          n_err++;
        end else begin
          e = solution_q.pop_front();
          if (out_beat_o.solution_index !== e.solution_index) begin
            $display("%0t: index exp %0d got %0d", $time, e.solution_index,
                     out_beat_o.solution_index);
            n_err++;
          end
          if (out_beat_o.solution_value !== e.solution_value) begin
            $display("%0t: value[%0d] exp %h got %h", $time, e.solution_index,
                     e.solution_value, out_beat_o.solution_value);
            n_err++;
          end
          if (out_beat_o.pivot_error !== e.pivot_error) begin
            $display("%0t: pivot_error[%0d] exp %b got %b", $time, e.solution_index,
                     e.pivot_error, out_beat_o.pivot_error);
            n_err++;
          end
          if (out_beat_o.last_result !== e.last_result) begin
            $display("%0t: last_result[%0d] exp %b got %b", $time, e.solution_index,
                     e.last_result, out_beat_o.last_result);
            n_err++;
          end
        end
      end
    end
  end

  initial begin
    int nup, r, c;
    for (int i = 0; i < N*N; i++) begin a_mat[i] = '0; l_mat[i] = '0; end
    for (int i = 0; i < N; i++) begin b_vec[i] = '0; y_vec[i] = '0; end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill every store entry the solve reads: identity A, b all ones, so x is all ones
    for (int i = 0; i < N; i++)
      for (int j = 0; j <= i; j++)
        dtab.push_back(row(mk(i, j, 0, (i == j) ? 32'h0001_0000 : 32'h0, 0)));
    for (int i = 0; i < N; i++)
      dtab.push_back(row(mk(i, 0, 1, 32'h0001_0000, i == N - 1), i == N - 1,
                         32'h0001_0000, 0));
    // zero pivot, then negative pivot: all zeros with the error flag
    dtab.push_back(row(mk(0, 0, 0, 32'h0, 1), 1, 32'h0, 1));
    dtab.push_back(row(mk(0, 0, 0, 32'h0001_0000, 0)));
    dtab.push_back(row(mk(3, 3, 0, 32'hFFFF_0000, 1), 1, 32'h0, 1));
    // extreme rhs values
    dtab.push_back(row(mk(3, 3, 0, 32'h0001_0000, 0)));
    dtab.push_back(row(mk(0, 5, 1, 32'h7FFF_FFFF, 0)));
    dtab.push_back(row(mk(7, 0, 1, 32'h8000_0000, 1)));
    // extreme matrix values: saturating off-diagonal, huge diagonal
    dtab.push_back(row(mk(7, 0, 0, 32'h8000_0000, 0)));
    dtab.push_back(row(mk(7, 7, 0, 32'h7FFF_FFFF, 1)));
    // restore, then out-of-range indices and an upper-triangle entry
    dtab.push_back(row(mk(7, 0, 0, 32'h0, 0)));
    dtab.push_back(row(mk(7, 7, 0, 32'h0001_0000, 0)));
    dtab.push_back(row(mk(8, 0, 0, 32'h1234_5678, 0)));
    dtab.push_back(row(mk(15, 15, 0, 32'hFFFF_FFFF, 0)));
    dtab.push_back(row(mk(9, 3, 1, 32'h7FFF_FFFF, 0)));
    dtab.push_back(row(mk(2, 15, 1, 32'h0002_0000, 0)));
    dtab.push_back(row(mk(0, 7, 0, 32'h5555_5555, 0)));
    dtab.push_back(row(mk(12, 3, 0, 32'hAAAA_AAAA, 1)));

    foreach (dtab[i]) send(dtab[i].beat, dtab[i].typed, dtab[i].tval, dtab[i].terr);

    // Random part: mostly diagonally dominant updates, some noise
    while (n_items < 280) begin
      if ($urandom_range(0, 3) == 0) calm = ~calm;
      if (!drained && n_items > 170) begin
        drained = 1'b1;
        in_valid_i = 1'b0;
        while (solution_q.size() != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 4) == 0) begin
        nup = $urandom_range(1, 3);
        for (int k = 0; k < nup; k++)
          send(mk($urandom_range(0, 15), $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                  $urandom, ($urandom_range(0, 5) == 0)));
      end else begin
        nup = $urandom_range(0, 6);
        for (int k = 0; k < nup; k++) begin
          r = $urandom_range(1, N - 1);
          c = $urandom_range(0, r - 1);
          if ($urandom_range(0, 7) == 0)
            send(mk(c, r, 0, $urandom, 0));   // upper triangle, unused by the solve
          else
            send(mk(r, c, 0, $urandom_range(0, 32'h2_0000) - 32'h1_0000, 0));
        end
        nup = $urandom_range(0, 3);
        for (int k = 0; k < nup; k++)
          send(mk($urandom_range(0, N - 1), $urandom_range(0, 15), 1,
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h40_0000), 0));
        for (int i = 0; i < N; i++)
          send(mk(i, i, 0, $urandom_range(32'h8_0000, 32'h40_0000), i == N - 1));
      end
    end

    in_valid_i = 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d input beats, %0d solves (%0d with a bad pivot), %0d result beats",
             n_items, n_solves, n_pivot_fail, n_results);
    if (n_err == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", n_err);
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
